### sv/gcv_pkg.sv
// gcv_pkg: shared types and constants for the gradient center vote block.
// No dependencies.
`timescale 1ns / 1ps
package gcv_pkg;
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int SCORE_W  = 48;
   localparam int WEIGHT_W = 8;
   localparam int GRAD_W   = 16;
   localparam int REG_W    = 7;
   localparam logic [REG_W-1:0] WIDTH_RST  = 7'd50;
   localparam logic [REG_W-1:0] HEIGHT_RST = 7'd40;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_WEIGHT = 2'd1,
      OP_VOTE   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_idx_type;
endpackage

### sv/gcv_ram.sv
// gcv_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/gcv_div.sv
// gcv_div: restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module gcv_div #(
   parameter int NW = 72,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW:0]   shl;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      shl = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (shl >= {1'b0, d_ff}) begin
            r_in = shl - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = shl;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = (cnt_ff != '0);
   assign quo  = q_ff;
endmodule

### sv/gradient_center_vote_core.sv
// gradient_center_vote_core: means-of-gradients center voting engine.
// After acceptance: weight write responds directly; clear sweeps the score map; vote, per
// candidate center, reads, forms dot and square, divides (72-bit restoring divider, one bit
// per cycle; skipped if dot <= 0 or at the point) and writes; report scans the region.
// One word at a time; req_tready is low while busy and while a response waits.
// Sync reset zeroes all 4096 score-map cells in a sweep, no word accepted meanwhile.
`timescale 1ns / 1ps
module gradient_center_vote_core
   import gcv_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], pos_x[7:2], pos_y[13:8], weight_value[21:14],
   // grad_x[37:22], grad_y[53:38], zero fill to 56
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // done_res[0], max_x[6:1], max_y[12:7], max_score[60:13], zero fill to 64
   output logic [63:0] rsp_tdata
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int NW = 72;
   localparam int DW = 32;
   localparam logic [SCORE_W-1:0] SAT = '1;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_VRD   = 9'b000000100,
      ST_VMUL  = 9'b000001000,
      ST_VMUL2 = 9'b000010000,
      ST_VDIV  = 9'b000100000,
      ST_VWR   = 9'b001000000,
      ST_RPT   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } st_type;

   st_type st_ff, st_in;
   logic [REG_W-1:0] rw_ff, rh_ff;
   logic [7:0] ew, eh;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [AW:0] clr_ff, clr_in;
   logic [5:0] px_ff, py_ff, bx_ff, by_ff, bx_in, by_in;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [SCORE_W-1:0] best_ff, best_in;
   logic any_ff, any_in, rv_ff, rv_in, rpt_ff, rpt_in, rd_ok_ff, rd_ok_in;
   logic signed [9:0] dx, dy;
   logic signed [25:0] dot_a, dot_b;
   logic signed [27:0] dot_ff;
   logic [27:0] udot;
   logic [55:0] sq_ff;
   logic [NW-1:0] num_c;
   logic [DW-1:0] den_ff;
   logic [19:0] dd;
   logic div_start, div_busy;
   logic [NW-1:0] quo;
   logic skip_ff;

   logic [1:0] f_op;
   logic [5:0] f_px, f_py;
   logic [7:0] f_wv;
   logic [AW-1:0] cell_addr, w_addr, s_wa;
   logic [WEIGHT_W-1:0] w_rd;
   logic [SCORE_W-1:0] s_rd, s_wd;
   logic s_we, w_we;
   logic [SCORE_W:0] sum;
   logic acc;

   assign f_op = req_tdata[1:0];
   assign f_px = req_tdata[7:2];
   assign f_py = req_tdata[13:8];
   assign f_wv = req_tdata[21:14];
   assign acc = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE) && !rv_ff;
   assign ew = (32'(rw_ff) > MAX_WIDTH) ? 8'(MAX_WIDTH) : {1'b0, rw_ff};
   assign eh = (32'(rh_ff) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : {1'b0, rh_ff};
   assign cell_addr = {cy_ff, cx_ff};
   assign w_addr = {YW'(f_py), XW'(f_px)};
   assign w_we = acc && (f_op == OP_WEIGHT) && (32'(f_px) < MAX_WIDTH)
                 && (32'(f_py) < MAX_HEIGHT);

   gcv_ram #(.WIDTH(WEIGHT_W), .DEPTH(DEPTH)) u_wmap (
      .clock(clock), .wr_en(w_we), .wr_addr(w_addr), .wr_data(f_wv),
      .rd_addr(cell_addr), .rd_data(w_rd));

   gcv_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_smap (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(cell_addr), .rd_data(s_rd));

   gcv_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(num_c),
      .den(den_ff), .busy(div_busy), .quo(quo));

   assign dx = $signed({4'b0, px_ff}) - $signed({{(10-XW){1'b0}}, cx_ff});
   assign dy = $signed({4'b0, py_ff}) - $signed({{(10-YW){1'b0}}, cy_ff});
   assign dot_a = dx * gx_ff;
   assign dot_b = dy * gy_ff;
   assign udot = dot_ff[27:0];
   assign dd = 20'(dx * dx) + 20'(dy * dy);
   assign num_c = 72'(sq_ff) * 72'(w_rd);
   assign sum = {1'b0, s_rd} + {1'b0, quo[SCORE_W-1:0]};

   // next cell in row-major order; returns last flag
   logic last_cell;
   logic [XW-1:0] nx;
   logic [YW-1:0] ny;
   always_comb begin
      last_cell = (8'(cx_ff) == ew - 8'd1) && (8'(cy_ff) == eh - 8'd1);
      if (8'(cx_ff) == ew - 8'd1) begin
         nx = '0;
         ny = cy_ff + 1'b1;
      end else begin
         nx = cx_ff + 1'b1;
         ny = cy_ff;
      end
   end

   always_comb begin
      st_in = st_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      clr_in = clr_ff;
      best_in = best_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      any_in = any_ff;
      rv_in = rv_ff;
      rpt_in = rpt_ff;
      rd_ok_in = rd_ok_ff;
      s_we = 1'b0;
      s_wa = cell_addr;
      s_wd = '0;
      div_start = 1'b0;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (st_ff)
         ST_CLEAR: begin
            s_we = 1'b1;
            s_wa = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff[AW-1:0] == '1) begin
               st_in = rpt_ff ? ST_OUT : ST_IDLE;
               rpt_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               cx_in = '0;
               cy_in = '0;
               any_in = 1'b0;
               best_in = '0;
               bx_in = '0;
               by_in = '0;
               case (op_type'(f_op))
                  OP_CLEAR: begin
                     clr_in = '0;
                     rpt_in = 1'b1;
                     st_in = ST_CLEAR;
                  end
                  OP_WEIGHT: st_in = ST_OUT;
                  OP_VOTE: begin
                     if ((req_tdata[37:22] == '0 && req_tdata[53:38] == '0)
                         || ew == 8'd0 || eh == 8'd0) begin
                        st_in = ST_OUT;
                     end else begin
                        st_in = ST_VRD;
                     end
                  end
                  OP_REPORT: begin
                     st_in = (ew == 8'd0 || eh == 8'd0) ? ST_OUT : ST_RPT;
                     rd_ok_in = 1'b0;
                  end
                  default: st_in = ST_OUT;
               endcase
            end
         end
         ST_VRD: st_in = ST_VMUL;
         ST_VMUL: st_in = ST_VMUL2;
         ST_VMUL2: begin
            div_start = !skip_ff;
            st_in = skip_ff ? ST_VWR : ST_VDIV;
         end
         ST_VDIV: begin
            if (!div_busy && !div_start) begin
               st_in = ST_VWR;
            end
         end
         ST_VWR: begin
            if (!skip_ff) begin
               s_we = 1'b1;
               s_wd = sum[SCORE_W] ? SAT : sum[SCORE_W-1:0];
            end
            cx_in = nx;
            cy_in = ny;
            st_in = last_cell ? ST_OUT : ST_VRD;
         end
         ST_RPT: begin
            // address presented one cycle, data compared the next
            if (rd_ok_ff) begin
               if (!any_ff || s_rd > best_ff) begin
                  any_in = 1'b1;
                  best_in = s_rd;
                  bx_in = 6'(cx_ff);
                  by_in = 6'(cy_ff);
               end
               rd_ok_in = 1'b0;
               cx_in = nx;
               cy_in = ny;
               if (last_cell) begin
                  st_in = ST_OUT;
               end
            end else begin
               rd_ok_in = 1'b1;
            end
         end
         ST_OUT: begin
            rv_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         rw_ff <= WIDTH_RST;
         rh_ff <= HEIGHT_RST;
         rv_ff <= 1'b0;
         rpt_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         rpt_ff <= rpt_in;
         rd_ok_ff <= rd_ok_in;
         any_ff <= any_in;
         if (csr_wr_en) begin
            case (reg_idx_type'(csr_index))
               REG_WIDTH: rw_ff <= csr_wdata;
               REG_HEIGHT: rh_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      best_ff <= best_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      if (acc) begin
         px_ff <= f_px;
         py_ff <= f_py;
         gx_ff <= $signed(req_tdata[37:22]);
         gy_ff <= $signed(req_tdata[53:38]);
      end
      // VRD: reads issued, dot registered; VMUL: square; VMUL2: weighted square into divider
      if (st_ff == ST_VRD) begin
         dot_ff <= 28'(dot_a) + 28'(dot_b);
         skip_ff <= (dx == '0 && dy == '0);
         den_ff <= {dd, 12'b0};
      end
      if (st_ff == ST_VMUL) begin
         sq_ff <= udot * udot;
         if (dot_ff[27] || dot_ff == '0) begin
            skip_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {3'b0, best_ff, by_ff, bx_ff, 1'b1};
endmodule

### tb/tb_gradient_center_vote_core.sv
// tb_gradient_center_vote_core: self-checking bench for the center vote core.
// A scoreboard class predicts every response word from its own weight and score maps.
// Depends on gcv_pkg and gradient_center_vote_core.
`timescale 1ns / 1ps
module tb_gradient_center_vote_core;
   import gcv_pkg::*;

   localparam int CELLS = 64 * 64;
   localparam int STALL_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   int gap_pct = 0;
   int stall_pct = 0;
   int idle_cnt = 0;
   int words_sent = 0;
   bit weight_set [CELLS];

   typedef struct {
      logic        done_res;
      logic [5:0]  max_x;
      logic [5:0]  max_y;
      logic [47:0] max_score;
   } rsp_word_type;

   function automatic int clamp64(int v);
      return (v > 64) ? 64 : v;
   endfunction

   class center_scoreboard;
      logic [7:0]       weights [CELLS];
      longint unsigned  scores [CELLS];
      int               width = 50;
      int               height = 40;
      rsp_word_type     pending_rsp [$];
      int               errors = 0;
      int               checked = 0;

      function new();
         foreach (scores[i]) scores[i] = 0;
         foreach (weights[i]) weights[i] = 0;
      endfunction

      function void apply_vote(int px, int py, int gx, int gy);
         longint dx, dy, dot;
         longint unsigned num, den, term, sum;
         int idx;
         if (gx == 0 && gy == 0) return;
         for (int cy = 0; cy < clamp64(height); cy++) begin
            for (int cx = 0; cx < clamp64(width); cx++) begin
               dx = px - cx;
               dy = py - cy;
               if (dx == 0 && dy == 0) continue;
               dot = dx * gx + dy * gy;
               if (dot <= 0) continue;
               idx = cy * 64 + cx;
               num = longint'(dot) * longint'(dot) * weights[idx];
               den = longint'(dx * dx + dy * dy) << 12;
               term = num / den;
               sum = scores[idx] + term;
               scores[idx] = (sum > 48'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum;
            end
         end
      endfunction

      function void note_request(logic [55:0] w);
         rsp_word_type r;
         op_type op;
         int px, py;
         longint unsigned best;
         bit any;
         op = op_type'(w[1:0]);
         px = int'(w[7:2]);
         py = int'(w[13:8]);
         r = '{1'b1, 6'd0, 6'd0, 48'd0};
         case (op)
            OP_CLEAR:  foreach (scores[i]) scores[i] = 0;
            OP_WEIGHT: weights[py * 64 + px] = w[21:14];
            OP_VOTE:   apply_vote(px, py, $signed(w[37:22]), $signed(w[53:38]));
            default: begin
               any = 0;
               best = 0;
               for (int cy = 0; cy < clamp64(height); cy++)
                  for (int cx = 0; cx < clamp64(width); cx++)
                     if (!any || scores[cy * 64 + cx] > best) begin
                        any = 1;
                        best = scores[cy * 64 + cx];
                        r.max_x = 6'(cx);
                        r.max_y = 6'(cy);
                     end
               r.max_score = 48'(best);
            end
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(logic [63:0] d);
         rsp_word_type e;
         if (pending_rsp.size() == 0) begin
            $error("response word with no request outstanding: %h", d);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         checked++;
         if (d[0] !== e.done_res) begin
            $error("done_res exp %0d got %0d", e.done_res, d[0]);
            errors++;
         end
         if (d[6:1] !== e.max_x) begin
            $error("max_x exp %0d got %0d", e.max_x, d[6:1]);
            errors++;
         end
         if (d[12:7] !== e.max_y) begin
            $error("max_y exp %0d got %0d", e.max_y, d[12:7]);
            errors++;
         end
         if (d[60:13] !== e.max_score) begin
            $error("max_score exp %0d got %0d", e.max_score, d[60:13]);
            errors++;
         end
      endfunction
   endclass

   center_scoreboard sb = new();

   gradient_center_vote_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready) sb.note_request(req_tdata);
      if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cnt = 0;
      end else begin
         idle_cnt++;
         if (idle_cnt >= STALL_LIMIT) begin
            $display("tb_gradient_center_vote_core NOT OK");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(op_type op, int px, int py, int wv, int gx, int gy);
      logic [55:0] w;
      w = {2'b00, 16'(gy), 16'(gx), 8'(wv), 6'(py), 6'(px), op};
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
      if (op == OP_WEIGHT) weight_set[py * 64 + px] = 1;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // fill: write every weight of the region that is still unwritten
   task automatic set_region(int w, int h, bit fill = 1'b1);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= REG_WIDTH;
      csr_wdata <= 7'(w);
      @(negedge clock);
      csr_index <= REG_HEIGHT;
      csr_wdata <= 7'(h);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.width = w;
      sb.height = h;
      if (fill)
         for (int y = 0; y < clamp64(h); y++)
            for (int x = 0; x < clamp64(w); x++)
               if (!weight_set[y * 64 + x])
                  send_word(OP_WEIGHT, x, y, $urandom_range(255), 0, 0);
   endtask

   function automatic int rand_grad();
      int k;
      k = $urandom_range(9);
      if (k < 6) return $urandom_range(32768) - 16384;
      if (k < 8) return $signed(16'($urandom));
      return 0;
   endfunction

   task automatic random_word(int w, int h);
      int k, gx, gy;
      k = $urandom_range(99);
      if (k < 25) begin
         if ($urandom_range(3) == 0)
            send_word(OP_WEIGHT, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                      $urandom, $urandom);
         else
            send_word(OP_WEIGHT, $urandom_range(clamp64(w) - 1), $urandom_range(clamp64(h) - 1),
                      $urandom_range(255), $urandom, $urandom);
      end else if (k < 70) begin
         gx = rand_grad();
         gy = ($urandom_range(19) == 0) ? 0 : rand_grad();
         if ($urandom_range(4) == 0)
            send_word(OP_VOTE, $urandom_range(63), $urandom_range(63), $urandom, gx, gy);
         else
            send_word(OP_VOTE, $urandom_range(clamp64(w) + 1), $urandom_range(clamp64(h) + 1),
                      $urandom, gx, gy);
      end else if (k < 92) begin
         send_word(OP_REPORT, $urandom_range(63), $urandom_range(63), $urandom, $urandom,
                   $urandom);
      end else begin
         send_word(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom, $urandom,
                   $urandom);
      end
   endtask

   initial begin
      int rw, rh;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      set_region(4, 3);

      // directed
      send_word(OP_WEIGHT, 0, 0, 255, 0, 0);
      send_word(OP_WEIGHT, 63, 63, 0, -1, -1);
      send_word(OP_VOTE, 1, 1, 0, 0, 0);
      send_word(OP_VOTE, 1, 1, 0, 16384, 0);
      send_word(OP_VOTE, 63, 63, 0, -16384, -16384);
      send_word(OP_VOTE, 2, 0, 255, -32768, 32767);
      send_word(OP_VOTE, 3, 2, 0, 16384, 16384);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      send_word(OP_CLEAR, 0, 0, 0, 0, 0);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      send_word(OP_VOTE, 0, 0, 0, -16384, -16384);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      set_region(0, 5);
      send_word(OP_VOTE, 2, 2, 0, 16384, 0);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      // oversized width: only the last column of the row gets a term
      set_region(127, 1, 1'b0);
      send_word(OP_WEIGHT, 63, 0, 200, 0, 0);
      send_word(OP_VOTE, 62, 0, 0, -16384, 0);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      // oversized height: only the last row of the column gets a term
      set_region(1, 127, 1'b0);
      send_word(OP_WEIGHT, 0, 63, 150, 0, 0);
      send_word(OP_VOTE, 0, 62, 0, 0, -16384);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      set_region(64, 64, 1'b0);
      send_word(OP_REPORT, 0, 0, 0, 0, 0);
      send_word(OP_CLEAR, 0, 0, 0, 0, 0);

      // random phases
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin rw = 1; rh = 1; end
            1: begin rw = 12; rh = 2; end
            2: begin rw = 6; rh = 6; end
            default: begin rw = $urandom_range(1, 5); rh = $urandom_range(1, 5); end
         endcase
         set_region(rw, rh);
         case (p % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 48; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 48; end
            default: begin gap_pct = 9; stall_pct = 9; end
         endcase
         for (int i = 0; i < 10; i++) random_word(rw, rh);
      end

      drain();
      $display("run: %0d request words sent, %0d responses checked, %0d errors",
               words_sent, sb.checked, sb.errors);
      $display("covered clear, weight, vote and report over empty, edge and small regions");
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("tb_gradient_center_vote_core OK");
      end else begin
         $display("tb_gradient_center_vote_core NOT OK");
      end
      $finish;
   end
endmodule
